FILE: hdl/fcne_pkg.sv
package fcne_pkg;

    localparam int MAX_NAME_DEF = 32;
    localparam int PFX_W        = 5;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 8;

    typedef logic [7:0] char_t;

    localparam char_t CODE_BASE     = 8'h80;
    localparam char_t CODE_INDEX    = 8'h40;
    localparam char_t CODE_OPERATOR = 8'h20;

    localparam logic [PFX_W-1:0] PREFIX_MAX = 5'h1F;

endpackage

FILE: hdl/front_coded_name_encoder_unit.sv
// Character beat: accepted, then compared against the previous name in the next cycle;
// s_tready is low during that compare (single name RAM read port and comparator) and while a name is emitted.
// Name end: S_CODE loads the code byte, then S_IDX the index byte, and each tail byte
// is read from RAM in S_RD and loaded in S_TAIL; each load waits for a free output register.
// Reset (aresetn low, synchronous) clears the sequencer, lengths and prefix state;
// the two name banks in RAM are not cleared and need no clearing pass.
module front_coded_name_encoder_unit #(
    parameter int MAX_NAME = fcne_pkg::MAX_NAME_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fcne_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] name_char, [23:8] entry_index
    input  logic                           s_tlast,
    input  logic [0:0]                     s_tuser,  // [0] is_operator
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fcne_pkg::M_TDATA_W-1:0] m_tdata,  // [7:0] out_byte
    output logic                           m_tlast
);
    import fcne_pkg::*;

    localparam int LEN_W = $clog2(MAX_NAME + 1);
    localparam int IDX_W = $clog2(MAX_NAME);
    localparam int CW    = (LEN_W > PFX_W) ? LEN_W : PFX_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_CODE = 3'd2;
    localparam logic [2:0] S_IDX  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_TAIL = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic             bank_reg, bank_next;
    logic [LEN_W-1:0] prev_len_reg, prev_len_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic [PFX_W-1:0] prefix_reg, prefix_next;
    logic             match_reg, match_next;
    logic [LEN_W-1:0] tail_reg, tail_next;
    char_t            ch_reg, ch_next;
    logic             end_reg, end_next;
    logic             op_reg, op_next;
    char_t            idx_byte_reg, idx_byte_next;
    logic             has_idx_reg, has_idx_next;
    logic             store_reg, store_next;
    logic             m_valid_reg, m_valid_next;
    char_t            m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;

    logic             pos_ok;
    logic             out_free;
    logic             tail_empty;
    logic             tail_done;
    logic             finish;
    logic             ram_we;
    logic [IDX_W:0]   ram_waddr;
    logic [IDX_W:0]   ram_raddr;
    char_t            ram_rdata;
    char_t            code_byte;

    fcne_name_ram #(
        .ADDR_W (IDX_W + 1)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (s_tdata[7:0]),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign pos_ok     = cur_len_reg < LEN_W'(MAX_NAME);
    assign out_free   = !m_valid_reg || m_tready;
    assign tail_empty = CW'(prefix_reg) >= CW'(cur_len_reg);
    assign tail_done  = LEN_W'(tail_reg + 1'b1) == cur_len_reg;
    assign ram_we     = (state_reg == S_IDLE) && s_tvalid && pos_ok;
    assign ram_waddr  = {~bank_reg, cur_len_reg[IDX_W-1:0]};
    assign ram_raddr  = (state_reg == S_RD || state_reg == S_TAIL)
                      ? {~bank_reg, tail_reg[IDX_W-1:0]}
                      : {bank_reg, cur_len_reg[IDX_W-1:0]};
    assign code_byte  = CODE_BASE | {3'b000, prefix_reg}
                      | (op_reg ? CODE_OPERATOR : 8'h00)
                      | (has_idx_reg ? CODE_INDEX : 8'h00);

    always_comb begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        prev_len_next = prev_len_reg;
        cur_len_next  = cur_len_reg;
        prefix_next   = prefix_reg;
        match_next    = match_reg;
        tail_next     = tail_reg;
        ch_next       = ch_reg;
        end_next      = end_reg;
        op_next       = op_reg;
        idx_byte_next = idx_byte_reg;
        has_idx_next  = has_idx_reg;
        store_next    = store_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_byte_next   = m_byte_reg;
        m_last_next   = m_last_reg;
        finish        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    ch_next       = s_tdata[7:0];
                    idx_byte_next = s_tdata[15:8];
                    has_idx_next  = s_tdata[23:16] == 8'h00;
                    end_next      = s_tlast;
                    op_next       = s_tuser[0];
                    store_next    = pos_ok;
                    state_next    = S_CMP;
                end
            end
            S_CMP: begin
                if (store_reg) begin
                    cur_len_next = LEN_W'(cur_len_reg + 1'b1);
                    if (match_reg && cur_len_reg < prev_len_reg &&
                        prefix_reg < PREFIX_MAX && ram_rdata == ch_reg) begin
                        prefix_next = PFX_W'(prefix_reg + 1'b1);
                    end else begin
                        match_next = 1'b0;
                    end
                end
                state_next = end_reg ? S_CODE : S_IDLE;
            end
            S_CODE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = code_byte;
                    m_last_next  = !has_idx_reg && tail_empty;
                    tail_next    = LEN_W'(prefix_reg);
                    if (has_idx_reg) begin
                        state_next = S_IDX;
                    end else if (!tail_empty) begin
                        state_next = S_RD;
                    end else begin
                        finish = 1'b1;
                    end
                end
            end
            S_IDX: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = idx_byte_reg;
                    m_last_next  = tail_empty;
                    if (tail_empty) begin
                        finish = 1'b1;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD: begin
                state_next = S_TAIL;
            end
            S_TAIL: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ram_rdata;
                    m_last_next  = tail_done;
                    tail_next    = LEN_W'(tail_reg + 1'b1);
                    if (tail_done) begin
                        finish = 1'b1;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (finish) begin
            bank_next     = ~bank_reg;
            prev_len_next = cur_len_reg;
            cur_len_next  = '0;
            prefix_next   = '0;
            match_next    = 1'b1;
            state_next    = S_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bank_reg     <= 1'b0;
            prev_len_reg <= '0;
            cur_len_reg  <= '0;
            prefix_reg   <= '0;
            match_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            prev_len_reg <= prev_len_next;
            cur_len_reg  <= cur_len_next;
            prefix_reg   <= prefix_next;
            match_reg    <= match_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tail_reg     <= tail_next;
        ch_reg       <= ch_next;
        end_reg      <= end_next;
        op_reg       <= op_next;
        idx_byte_reg <= idx_byte_next;
        has_idx_reg  <= has_idx_next;
        store_reg    <= store_next;
        m_byte_reg   <= m_byte_next;
        m_last_reg   <= m_last_next;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;

    a_prefix_le_len: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(prefix_reg) <= CW'(cur_len_reg))
        else $error("shared prefix exceeds current length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_len_reg <= LEN_W'(MAX_NAME) && prev_len_reg <= LEN_W'(MAX_NAME))
        else $error("name length beyond limit");

    a_tail_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RD || state_reg == S_TAIL) |-> tail_reg < cur_len_reg)
        else $error("tail pointer past end of name");

    a_beat_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a character is being compared");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

endmodule

FILE: hdl/fcne_name_ram.sv
module fcne_name_ram #(
    parameter int ADDR_W = 6
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  fcne_pkg::char_t     wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output fcne_pkg::char_t     rd_data
);
    import fcne_pkg::*;

    char_t mem [2**ADDR_W];
    char_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: verif/front_coded_name_encoder_unit_test.sv
`timescale 1ns / 1ps

module front_coded_name_encoder_unit_test;
    import fcne_pkg::*;

    localparam int NAME_MAX   = MAX_NAME_DEF;
    localparam int CYCLE_CAP  = 200000;
    localparam int BEAT_GOAL  = 265;
    localparam int CALM_AFTER = 220;

    typedef struct packed {
        char_t data;
        logic  last;
    } code_byte_t;

    class front_code_tracker;
        char_t      prev_name [NAME_MAX];
        char_t      cur_name [NAME_MAX];
        int         prev_len;
        int         cur_len;
        int         prefix;
        bit         matching;
        code_byte_t bytes_due [$];
        int         errors;

        function new();
            prev_len = 0;
            cur_len  = 0;
            prefix   = 0;
            matching = 1'b1;
            errors   = 0;
        endfunction

        function int due();
            return bytes_due.size();
        endfunction

        function void push_byte(char_t data, logic last);
            code_byte_t b;
            b.data = data;
            b.last = last;
            bytes_due.push_back(b);
        endfunction

        function void take_char(char_t ch, bit fin, bit op, logic [15:0] idx);
            char_t code;
            bit    has_idx;
            if (cur_len < NAME_MAX) begin
                if (matching && cur_len < prev_len && prefix < int'(PREFIX_MAX)
                        && prev_name[cur_len] == ch) begin
                    prefix++;
                end else begin
                    matching = 1'b0;
                end
                cur_name[cur_len] = ch;
                cur_len++;
            end
            if (!fin)
                return;
            has_idx = idx < 16'd256;
            code = CODE_BASE | char_t'(prefix);
            if (op)
                code = code | CODE_OPERATOR;
            if (has_idx)
                code = code | CODE_INDEX;
            push_byte(code, !has_idx && prefix >= cur_len);
            if (has_idx)
                push_byte(idx[7:0], prefix >= cur_len);
            for (int i = prefix; i < cur_len; i++)
                push_byte(cur_name[i], i + 1 == cur_len);
            prev_name = cur_name;
            prev_len  = cur_len;
            cur_len   = 0;
            prefix    = 0;
            matching  = 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task match_byte(char_t data, logic last);
            code_byte_t b;
            if (bytes_due.size() == 0) begin
                report($sformatf("unexpected beat data=%h last=%b", data, last));
                return;
            end
            b = bytes_due.pop_front();
            if (data !== b.data)
                report($sformatf("out_byte got %h want %h", data, b.data));
            if (last !== b.last)
                report($sformatf("out_last got %b want %b (byte %h)", last, b.last, b.data));
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tlast  = 1'b0;
    logic [0:0]           s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    front_code_tracker board;
    bit                calm       = 1'b0;
    int                beats_sent = 0;
    int                cycles     = 0;
    char_t             last_sent [$];

    front_coded_name_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.match_byte(m_tdata, m_tlast);
    end

    // result side backpressure
    initial begin : sink
        int n;
        @(posedge aclk);
        forever begin
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                n = $urandom_range(1, 9);
                m_tready <= ($urandom_range(0, 2) != 0);
                repeat (n) @(posedge aclk);
            end
        end
    end

    task automatic hold_off(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic put_beat(char_t ch, bit fin, bit op, logic [15:0] idx);
        s_tvalid <= 1'b1;
        s_tdata  <= {idx, ch};
        s_tlast  <= fin;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        board.take_char(ch, fin, op, idx);
        beats_sent++;
    endtask

    // op and index only matter on the final beat; earlier beats carry junk there
    task automatic send_name(char_t chars [$], bit op, logic [15:0] idx);
        bit fin;
        for (int i = 0; i < chars.size(); i++) begin
            fin = (i == chars.size() - 1);
            if (!calm && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 9));
            if (fin)
                put_beat(chars[i], 1'b1, op, idx);
            else
                put_beat(chars[i], 1'b0, 1'($urandom_range(0, 1)),
                         16'($urandom_range(0, 65535)));
        end
        last_sent = chars;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.due() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic random_name();
        char_t       nm [$];
        int          len;
        int          keep;
        bit          long_one;
        logic [15:0] idx;
        long_one = (last_sent.size() > 28) ? 1'($urandom_range(0, 1))
                                           : ($urandom_range(0, 9) == 0);
        len  = long_one ? $urandom_range(30, 40) : $urandom_range(1, 8);
        keep = ($urandom_range(0, 3) != 0) ? $urandom_range(0, last_sent.size()) : 0;
        if (long_one && $urandom_range(0, 1) == 1)
            keep = last_sent.size();
        for (int i = 0; i < len; i++) begin
            if (i < keep)
                nm.push_back(last_sent[i]);
            else if ($urandom_range(0, 1) == 1)
                nm.push_back(char_t'($urandom_range(8'h61, 8'h64)));
            else
                nm.push_back(char_t'($urandom_range(0, 255)));
        end
        idx = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                   : 16'($urandom_range(0, 65535));
        send_name(nm, 1'($urandom_range(0, 1)), idx);
    endtask

    initial begin : stimulus
        char_t nm [$];
        bit    paused_mid;
        paused_mid = 1'b0;
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // first name after reset: whole name goes out
        nm = '{8'h00, 8'hFF, 8'h41};
        send_name(nm, 1'b0, 16'd0);
        // identical name, index byte carries last
        send_name(nm, 1'b1, 16'd255);
        // identical name, no index, code byte carries last
        send_name(nm, 1'b0, 16'd256);
        nm = '{8'h00, 8'hFF};
        send_name(nm, 1'b1, 16'hFFFF);
        // previous name shorter: matching stops at its length
        nm = '{8'h00, 8'hFF, 8'h41, 8'h42, 8'h43};
        send_name(nm, 1'b0, 16'd17);
        nm = '{8'h01};
        send_name(nm, 1'b1, 16'd128);
        drain();

        while (beats_sent < BEAT_GOAL) begin
            if (beats_sent > CALM_AFTER)
                calm = 1'b1;
            random_name();
            if (!paused_mid && beats_sent > 150) begin
                drain();
                paused_mid = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        while (board.due() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (board.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
hdl/fcne_pkg.sv
hdl/fcne_name_ram.sv
hdl/front_coded_name_encoder_unit.sv
verif/front_coded_name_encoder_unit_test.sv
